FILE: src/tsld_pkg.sv
`default_nettype none

package tsld_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int TICK_BITS_DEF  = 16;

    localparam int AREA_BITS   = 12;
    localparam int LPT_BITS    = 16;
    localparam int RPT_BITS    = 12;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [1:0] t_mode;
    typedef logic [2:0] t_gesture;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_mode MODE_DOWN  = 2'd0;
    localparam t_mode MODE_ABORT = 2'd1;
    localparam t_mode MODE_UP    = 2'd2;
    localparam t_mode MODE_TICK  = 2'd3;

    localparam t_gesture G_LONG  = 3'd0;
    localparam t_gesture G_RIGHT = 3'd1;
    localparam t_gesture G_LEFT  = 3'd2;
    localparam t_gesture G_DOWN  = 3'd3;
    localparam t_gesture G_UP    = 3'd4;

    localparam t_cfg_idx REG_AREA_LEFT   = 3'd0;
    localparam t_cfg_idx REG_AREA_TOP    = 3'd1;
    localparam t_cfg_idx REG_AREA_WIDTH  = 3'd2;
    localparam t_cfg_idx REG_AREA_HEIGHT = 3'd3;
    localparam t_cfg_idx REG_SWIPE_MIN   = 3'd4;
    localparam t_cfg_idx REG_LP_TICKS    = 3'd5;

    localparam logic [AREA_BITS-1:0] RST_AREA_LEFT   = 12'd0;
    localparam logic [AREA_BITS-1:0] RST_AREA_TOP    = 12'd0;
    localparam logic [AREA_BITS-1:0] RST_AREA_WIDTH  = 12'd240;
    localparam logic [AREA_BITS-1:0] RST_AREA_HEIGHT = 12'd240;
    localparam logic [AREA_BITS-1:0] RST_SWIPE_MIN   = 12'd80;
    localparam logic [LPT_BITS-1:0]  RST_LP_TICKS    = 16'd1000;

endpackage

`default_nettype wire

FILE: src/tsld_if.sv
`default_nettype none

interface tsld_in_if #(
    parameter int COORD_BITS = tsld_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    tsld_pkg::t_mode       mode;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;

    modport source (output valid, output mode, output point_x, output point_y, input ready);
    modport sink   (input valid, input mode, input point_x, input point_y, output ready);
endinterface

interface tsld_out_if;
    logic                               valid;
    logic                               ready;
    tsld_pkg::t_gesture                 gesture;
    logic [tsld_pkg::RPT_BITS-1:0]      report_x;
    logic [tsld_pkg::RPT_BITS-1:0]      report_y;

    modport source (output valid, output gesture, output report_x, output report_y, input ready);
    modport sink   (input valid, input gesture, input report_x, input report_y, output ready);
endinterface

interface tsld_cfg_if;
    logic                               valid;
    logic                               ready;
    tsld_pkg::t_cfg_idx                 index;
    logic [tsld_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/touch_swipe_long_press_detector_core.sv
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while the result side is ready.
// A result waiting on a stalled output still lets one more item into the input register.
// Reset: synchronous, active low; clears pressed flag, tick counter, valids and
// loads the register defaults (area 0,0 240x240, min distance 80, 1000 ticks).
`default_nettype none

module touch_swipe_long_press_detector_core #(
    parameter int COORD_BITS = tsld_pkg::COORD_BITS_DEF,
    parameter int TICK_BITS  = tsld_pkg::TICK_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    tsld_in_if.sink      i_item,
    tsld_out_if.source   o_result,
    tsld_cfg_if.sink     i_cfg
);

    localparam int AB = tsld_pkg::AREA_BITS;
    localparam int XW = (COORD_BITS > AB) ? COORD_BITS : AB;
    localparam int CW = XW + 1;
    localparam int FW = ((COORD_BITS + 3) > AB) ? (COORD_BITS + 3) : AB;
    localparam int KW = (TICK_BITS > tsld_pkg::LPT_BITS) ? TICK_BITS : tsld_pkg::LPT_BITS;

    // configuration
    logic [AB-1:0]                 r_area_left, r_area_top, r_area_width, r_area_height;
    logic [AB-1:0]                 r_swipe_min;
    logic [tsld_pkg::LPT_BITS-1:0] r_lp_ticks;

    // input stage
    logic                  r_in_valid;
    tsld_pkg::t_mode       r_mode;
    logic [COORD_BITS-1:0] r_x, r_y;

    // gesture state
    logic                  r_pressed, n_pressed;
    logic [COORD_BITS-1:0] r_press_x, r_press_y;
    logic [TICK_BITS-1:0]  r_hold, n_hold;

    // result stage
    logic                           r_out_valid;
    tsld_pkg::t_gesture             r_gesture, n_gesture;
    logic [tsld_pkg::RPT_BITS-1:0]  r_rep_x, r_rep_y, n_rep_x, n_rep_y;
    logic                           n_emit;

    logic advance, process;
    logic [COORD_BITS-1:0] dx, dy;
    logic [TICK_BITS-1:0]  hold_inc;
    logic in_area, moved, horiz, small_x, small_y, fire;

    assign advance        = !r_out_valid || o_result.ready;
    assign process        = r_in_valid && advance;
    assign i_item.ready   = !r_in_valid || advance;
    assign i_cfg.ready    = 1'b1;

    assign o_result.valid    = r_out_valid;
    assign o_result.gesture  = r_gesture;
    assign o_result.report_x = r_rep_x;
    assign o_result.report_y = r_rep_y;

    always_comb begin
        dx = (r_press_x > r_x) ? (r_press_x - r_x) : (r_x - r_press_x);
        dy = (r_press_y > r_y) ? (r_press_y - r_y) : (r_y - r_press_y);
        in_area = (CW'(r_x) >= CW'(r_area_left))
               && (CW'(r_x) <  CW'(r_area_left) + CW'(r_area_width))
               && (CW'(r_y) >= CW'(r_area_top))
               && (CW'(r_y) <  CW'(r_area_top) + CW'(r_area_height));
        moved   = (r_x != r_press_x) || (r_y != r_press_y);
        horiz   = dx > dy;
        small_x = (FW'(dx) < FW'(r_swipe_min))
               && ((FW'(dx) << 2) + FW'(dx) < FW'(r_area_width));
        small_y = (FW'(dy) < FW'(r_swipe_min))
               && ((FW'(dy) << 2) + FW'(dy) < FW'(r_area_height));
        hold_inc = (r_hold == {TICK_BITS{1'b1}}) ? r_hold : r_hold + 1'b1;
        fire     = KW'(hold_inc) >= KW'(r_lp_ticks);
    end

    always_comb begin
        n_pressed = r_pressed;
        n_hold    = r_hold;
        n_emit    = 1'b0;
        n_gesture = tsld_pkg::G_LONG;
        n_rep_x   = '0;
        n_rep_y   = '0;
        unique case (r_mode)
            tsld_pkg::MODE_DOWN: begin
                n_pressed = 1'b1;
                n_hold    = '0;
            end
            tsld_pkg::MODE_ABORT: begin
                n_pressed = 1'b0;
                n_hold    = '0;
            end
            tsld_pkg::MODE_TICK: begin
                if (r_pressed) begin
                    n_hold = hold_inc;
                    if (fire) begin
                        n_pressed = 1'b0;
                        n_hold    = '0;
                        n_emit    = 1'b1;
                    end
                end
            end
            tsld_pkg::MODE_UP: begin
                n_pressed = 1'b0;
                n_hold    = '0;
                n_rep_x   = tsld_pkg::RPT_BITS'(r_x);
                n_rep_y   = tsld_pkg::RPT_BITS'(r_y);
                if (r_pressed && in_area && moved) begin
                    if (horiz) begin
                        n_emit    = !small_x;
                        n_gesture = (r_x > r_press_x) ? tsld_pkg::G_RIGHT : tsld_pkg::G_LEFT;
                    end else begin
                        n_emit    = !small_y;
                        n_gesture = (r_y > r_press_y) ? tsld_pkg::G_DOWN : tsld_pkg::G_UP;
                    end
                end
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_left   <= tsld_pkg::RST_AREA_LEFT;
            r_area_top    <= tsld_pkg::RST_AREA_TOP;
            r_area_width  <= tsld_pkg::RST_AREA_WIDTH;
            r_area_height <= tsld_pkg::RST_AREA_HEIGHT;
            r_swipe_min   <= tsld_pkg::RST_SWIPE_MIN;
            r_lp_ticks    <= tsld_pkg::RST_LP_TICKS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tsld_pkg::REG_AREA_LEFT:   r_area_left   <= i_cfg.data[AB-1:0];
                tsld_pkg::REG_AREA_TOP:    r_area_top    <= i_cfg.data[AB-1:0];
                tsld_pkg::REG_AREA_WIDTH:  r_area_width  <= i_cfg.data[AB-1:0];
                tsld_pkg::REG_AREA_HEIGHT: r_area_height <= i_cfg.data[AB-1:0];
                tsld_pkg::REG_SWIPE_MIN:   r_swipe_min   <= i_cfg.data[AB-1:0];
                tsld_pkg::REG_LP_TICKS:    r_lp_ticks    <= i_cfg.data[tsld_pkg::LPT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pressed   <= 1'b0;
            r_hold      <= '0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= process && n_emit;
            end
            if (process) begin
                r_pressed <= n_pressed;
                r_hold    <= n_hold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_mode <= i_item.mode;
            r_x    <= i_item.point_x;
            r_y    <= i_item.point_y;
        end
        if (process && r_mode == tsld_pkg::MODE_DOWN) begin
            r_press_x <= r_x;
            r_press_y <= r_y;
        end
        if (advance) begin
            r_gesture <= n_gesture;
            r_rep_x   <= n_rep_x;
            r_rep_y   <= n_rep_y;
        end
    end

endmodule

`default_nettype wire

FILE: src/tsld_checker.sv
`default_nettype none

module tsld_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_ready,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [2:0]                    i_gesture,
    input wire [tsld_pkg::RPT_BITS-1:0] i_report_x,
    input wire [tsld_pkg::RPT_BITS-1:0] i_report_y
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_gesture)
            && $stable(i_report_x) && $stable(i_report_y))
        else $error("result changed while stalled");

    a_gesture_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_gesture == tsld_pkg::G_LONG || i_gesture == tsld_pkg::G_RIGHT
            || i_gesture == tsld_pkg::G_LEFT || i_gesture == tsld_pkg::G_DOWN
            || i_gesture == tsld_pkg::G_UP))
        else $error("gesture code out of range");

    a_long_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_gesture == tsld_pkg::G_LONG |-> i_report_x == '0 && i_report_y == '0)
        else $error("long press with nonzero coordinates");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output drains");

endmodule

bind touch_swipe_long_press_detector_core tsld_checker u_tsld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_gesture   (o_result.gesture),
    .i_report_x  (o_result.report_x),
    .i_report_y  (o_result.report_y)
);

`default_nettype wire
